// ----- rtl/rpn_pkg.sv -----
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int OPCODE_W    = 3;
  localparam int DIGIT_W     = 4;
  localparam int STATUS_W    = 3;
  localparam int DIGIT_MAX   = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEP_W  = $clog2(WORD_W);

  typedef enum logic [OPCODE_W-1:0] {
    OP_DIGIT   = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_END     = 3'd5,
    OP_INVALID = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_RESULT   = 3'd1,
    ST_FEW      = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_INVALID  = 3'd4,
    ST_COUNT    = 3'd5,
    ST_FULL     = 3'd6,
    ST_SKIPPED  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_END,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [DIGIT_W-1:0] digit;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DIV,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/rpn_if.sv -----
`default_nettype none

interface rpn_in_if import rpn_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [DIGIT_W-1:0]  digit;

  modport source (output valid, output opcode, output digit, input ready);
  modport sink   (input valid, input opcode, input digit, output ready);
endinterface

interface rpn_out_if import rpn_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output status, output value, input ready);
  modport sink   (input valid, input status, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/rpn_front.sv -----
`default_nettype none

module rpn_front import rpn_pkg::*; (
  rpn_in_if.sink in,
  output logic   push_valid,
  input  logic   push_ready,
  output cmd_t   push_cmd
);

  always_comb begin
    push_cmd.digit = in.digit;
    unique case (in.opcode)
      OP_DIGIT: begin
        // Digits above nine are malformed tokens.
        push_cmd.kind = (in.digit > DIGIT_W'(DIGIT_MAX)) ? CMD_BAD : CMD_PUSH;
      end
      OP_ADD:  push_cmd.kind = CMD_ADD;
      OP_SUB:  push_cmd.kind = CMD_SUB;
      OP_MUL:  push_cmd.kind = CMD_MUL;
      OP_DIV:  push_cmd.kind = CMD_DIV;
      OP_END:  push_cmd.kind = CMD_END;
      default: push_cmd.kind = CMD_BAD;
    endcase
  end

  assign push_valid = in.valid;
  assign in.ready   = push_ready;

endmodule

`default_nettype wire

// ----- rtl/rpn_queue.sv -----
`default_nettype none

module rpn_queue import rpn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t               ent [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = ent[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) ent[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rpn_div.sv -----
`default_nettype none

module rpn_div import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  fix;
  logic                  neg;
  logic [DIV_STEP_W-1:0] step;
  logic [WORD_W-1:0]     rem;
  logic [WORD_W-1:0]     quo;
  logic [WORD_W-1:0]     dmag;
  logic [WORD_W:0]       rem_sh;
  logic [WORD_W:0]       diff;
  logic [WORD_W-1:0]     lmag;
  logic [WORD_W-1:0]     rmag;

  assign lmag   = req.dividend[WORD_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign rmag   = req.divisor[WORD_W-1]  ? (~req.divisor + 1'b1)  : req.divisor;
  assign rem_sh = {rem, quo[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dmag};

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= lmag;
      dmag <= rmag;
      neg  <= req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
    end else if (busy) begin
      if (!diff[WORD_W]) rem <= diff[WORD_W-1:0];
      else rem <= rem_sh[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], ~diff[WORD_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fix      <= 1'b0;
      step     <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= fix;
      fix      <= 1'b0;
      if (fix) rsp.quotient <= neg ? (~quo + 1'b1) : quo;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == DIV_STEP_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rpn_back.sv -----
`default_nettype none

module rpn_back import rpn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output div_req_t   div_req,
  input  div_rsp_t   div_rsp,
  rpn_out_if.source  out
);

  // Top of stack lives in tos; entries below it live in mem[0 .. cnt-2].
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data;

  back_state_t       state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              aborted, aborted_next;
  logic [WORD_W-1:0] tos, tos_next;
  cmd_kind_t         op, op_next;
  logic [WORD_W-1:0] res, res_next;
  status_t           res_st, res_st_next;

  logic              out_valid;
  status_t           out_status;
  logic [WORD_W-1:0] out_value;

  logic              out_free;
  logic              emit;
  status_t           emit_status;
  logic [WORD_W-1:0] emit_value;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;

  assign out_free = !out_valid || out.ready;
  assign wr_addr  = PTR_W'(cnt - 1'b1);
  assign rd_addr  = PTR_W'(cnt - 2'd2);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    aborted_next = aborted;
    tos_next     = tos;
    op_next      = op;
    res_next     = res;
    res_st_next  = res_st;
    cmd_ready    = 1'b0;
    emit         = 1'b0;
    emit_status  = ST_ACCEPTED;
    emit_value   = '0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rd_data;
    div_req.divisor  = tos;

    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          priority if (cmd.kind == CMD_END) begin
            emit = 1'b1;
            if (aborted) emit_status = ST_SKIPPED;
            else if (cnt == CNT_W'(1)) begin
              emit_status = ST_RESULT;
              emit_value  = tos;
            end else emit_status = ST_COUNT;
            cnt_next     = '0;
            aborted_next = 1'b0;
          end else if (aborted) begin
            emit        = 1'b1;
            emit_status = ST_SKIPPED;
          end else if (cmd.kind == CMD_BAD) begin
            emit         = 1'b1;
            emit_status  = ST_INVALID;
            aborted_next = 1'b1;
          end else if (cmd.kind == CMD_PUSH) begin
            emit = 1'b1;
            if (cnt == CNT_W'(STACK_DEPTH)) begin
              emit_status  = ST_FULL;
              aborted_next = 1'b1;
            end else begin
              // Spill the old top into the memory, load the digit as new top.
              wr_en       = (cnt != '0);
              tos_next    = WORD_W'(cmd.digit);
              cnt_next    = cnt + 1'b1;
              emit_status = ST_ACCEPTED;
              emit_value  = WORD_W'(cmd.digit);
            end
          end else if (cnt < CNT_W'(2)) begin
            emit         = 1'b1;
            emit_status  = ST_FEW;
            aborted_next = 1'b1;
          end else begin
            // Fetch the left operand; it is ready in rd_data next cycle.
            rd_en      = 1'b1;
            op_next    = cmd.kind;
            state_next = BK_EXEC;
          end
        end
      end

      BK_EXEC: begin
        res_st_next = ST_ACCEPTED;
        state_next  = BK_FINISH;
        unique case (op)
          CMD_ADD: res_next = rd_data + tos;
          CMD_SUB: res_next = rd_data - tos;
          CMD_MUL: res_next = rd_data * tos;
          default: begin
            if (tos == '0) begin
              res_next    = '0;
              res_st_next = ST_DIVZERO;
            end else begin
              div_req.start = 1'b1;
              state_next    = BK_DIV;
            end
          end
        endcase
      end

      BK_DIV: begin
        if (div_rsp.done) begin
          res_next   = div_rsp.quotient;
          state_next = BK_FINISH;
        end
      end

      BK_FINISH: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = res_st;
          emit_value  = res;
          if (res_st == ST_ACCEPTED) begin
            tos_next = res;
            cnt_next = cnt - 1'b1;
          end else begin
            cnt_next     = cnt - 2'd2;
            aborted_next = 1'b1;
          end
          state_next = BK_IDLE;
        end
      end

      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= tos;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      aborted   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cnt     <= cnt_next;
      aborted <= aborted_next;
      if (emit) out_valid <= 1'b1;
      else if (out.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tos    <= tos_next;
    op     <= op_next;
    res    <= res_next;
    res_st <= res_st_next;
    if (emit) begin
      out_status <= emit_status;
      out_value  <= emit_value;
    end
  end

  assign out.valid  = out_valid;
  assign out.status = out_status;
  assign out.value  = out_value;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_exec_after_read: assert property (@(posedge clk) disable iff (rst)
    state == BK_EXEC |-> $past(rd_en))
    else $error("operator executed without an operand fetch");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV && !div_rsp.done) |=> state == BK_DIV)
    else $error("left divide wait before quotient");

  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FINISH && !out_free) |=> (state == BK_FINISH && $stable(res)))
    else $error("result lost while output stalled");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_status == ST_RESULT) |=> (cnt == '0 && !aborted))
    else $error("stack not cleared after end");

endmodule

`default_nettype wire

// ----- rtl/rpn_stack_evaluator.sv -----
`default_nettype none

// Postfix expression evaluator on a 32-bit operand stack of STACK_DEPTH
// entries. Each token on "in" yields exactly one transaction on "out" with a
// status and a value (new top on accept, final value on result, else zero).
// After any error the evaluator reports skipped for every token until the end
// token, which clears the stack. Tokens enter a two-entry command queue after
// classification, so the input keeps taking tokens, until the queue is full,
// while the executor works and while a result waits on "out". Digit, end and
// error tokens are handled in the idle state; add, subtract and multiply go
// through operand fetch from the stack memory read port, execute and write
// back; divide adds the radix-2 divider (one quotient bit per cycle) and its
// sign fix before write back, unless the divisor is zero. The top of stack is
// held in a register and the entries beneath it in a single-port-write,
// single-port-read memory; no clearing pass is needed after reset.
module rpn_stack_evaluator import rpn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rpn_in_if.sink     in,
  rpn_out_if.source  out
);

  logic     push_valid;
  logic     push_ready;
  cmd_t     push_cmd;
  logic     cmd_valid;
  logic     cmd_ready;
  cmd_t     cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Classify raw tokens: malformed digits and unused opcodes become invalid.
  rpn_front u_front (
    .in         (in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decouple token intake from execution.
  rpn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_cmd    (cmd)
  );

  // Stack, error tracking and the result register.
  rpn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out       (out)
  );

  // Truncating signed divide, one bit per cycle.
  rpn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

`default_nettype wire
